FILE: rtl/chunked_handle_pool_allocator_core_defines.svh
// Assertion macros for the chunked handle pool allocator.
// Included by the files that carry concurrent assertions; no other dependencies.
`ifndef CHUNKED_HANDLE_POOL_ALLOCATOR_CORE_DEFINES_SVH
`define CHUNKED_HANDLE_POOL_ALLOCATOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define CHPA_ASSERT_IMPLY(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |-> (post)) \
    else $error("chpa assertion failed");
// next-cycle implication
`define CHPA_ASSERT_NEXT(label, clk_s, rst_s, pre, post) \
  label: assert property (@(posedge clk_s) disable iff (!rst_s) (pre) |=> (post)) \
    else $error("chpa assertion failed");
`else
`define CHPA_ASSERT_IMPLY(label, clk_s, rst_s, pre, post)
`define CHPA_ASSERT_NEXT(label, clk_s, rst_s, pre, post)
`endif
`endif

FILE: rtl/chpa_pkg.sv
// Shared constants for the chunked handle pool allocator: field widths,
// action and status codes, default geometry. No dependencies.
package chpa_pkg;

  localparam int HANDLE_W   = 11;
  localparam int ACTION_W   = 2;
  localparam int STATUS_W   = 2;
  localparam int OFFSET_W   = 22;
  localparam int COUNT_W    = 7;
  localparam int ESIZE_W    = 13;
  localparam int FREE_DEPTH = 1024;
  localparam int FREE_AW    = 10;
  localparam int FREE_TOP_W = 11;

  localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;
  localparam logic [ESIZE_W-1:0] ESIZE_RESET = 13'd16;

  localparam int CHUNK_ELEMENTS  = 64;
  localparam int ELEM_INDEX_BITS = 7;
  localparam int MAX_CHUNKS      = 16;

  localparam logic [ACTION_W-1:0] ACT_ALLOC  = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_FREE   = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_LOOKUP = 2'd2;
  localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd3;

endpackage

FILE: rtl/chpa_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// Used for the free stack and the per-chunk free counts; no dependencies.
module chpa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/chunked_handle_pool_allocator_core.sv
// Channel | Dir | Signals                       | Content
// in_     | in  | tvalid tready tdata tuser     | request: action, handle
// out_    | out | tvalid tready tdata tuser     | result: status, handle, offset, count
// cfg_    | in  | we wdata                      | element_size register
// One request at a time: allocate from the free list runs S_STK (stack read),
// S_CNT (count read-modify-write) and S_MUL (offset multiply); other valid requests
// skip S_STK, rejected ones go to S_MUL, which waits for the output register to drain.
// The registered reads of the stack RAM and the count RAM set this sequence of states.
// Reset is synchronous, active low; it clears control state only. The count RAM
// needs no clearing: a chunk's count is written to zero when the chunk opens.
// A new request is taken while a finished result still waits in the output register.
// Depends on chpa_pkg, chpa_ram and chunked_handle_pool_allocator_core_defines.svh.
`include "chunked_handle_pool_allocator_core_defines.svh"
module chunked_handle_pool_allocator_core #(
  parameter int CHUNK_ELEMENTS  = chpa_pkg::CHUNK_ELEMENTS,
  parameter int ELEM_INDEX_BITS = chpa_pkg::ELEM_INDEX_BITS,
  parameter int MAX_CHUNKS      = chpa_pkg::MAX_CHUNKS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [15:0]                   in_tdata,   // [10:0] handle_in, rest zero
  input  logic [chpa_pkg::ACTION_W-1:0] in_tuser,   // [1:0] action
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [39:0]                   out_tdata,  // [10:0] handle_out, [32:11] slot_offset,
                                                    // [39:33] chunk_free_count
  output logic [chpa_pkg::STATUS_W-1:0] out_tuser,  // [1:0] status
  input  logic                          cfg_we,
  input  logic [chpa_pkg::ESIZE_W-1:0]  cfg_wdata   // element_size
);
  import chpa_pkg::*;

  localparam int CIU_W   = $clog2(MAX_CHUNKS + 1);
  localparam int FILL_W  = $clog2(CHUNK_ELEMENTS + 1);
  localparam int CA_W    = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
  localparam int LIN_RAW = $clog2((2 ** (HANDLE_W - ELEM_INDEX_BITS)) * CHUNK_ELEMENTS
                                  + (2 ** ELEM_INDEX_BITS));
  localparam int LIN_W   = (LIN_RAW > OFFSET_W) ? OFFSET_W : LIN_RAW;
  localparam int PROD_W  = LIN_W + ESIZE_W;
  localparam logic [HANDLE_W-1:0] ELEM_MASK = HANDLE_W'((32'd1 << ELEM_INDEX_BITS) - 32'd1);

  typedef enum logic [1:0] {S_IDLE, S_STK, S_CNT, S_MUL} state_t;
  typedef enum logic [2:0] {CM_NONE, CM_KEEP, CM_DEC, CM_INC, CM_ZERO} cmode_t;

  state_t                state_r;
  cmode_t                cmode_r;
  logic [ESIZE_W-1:0]    esize_r;
  logic [FREE_TOP_W-1:0] free_top_r;
  logic [CIU_W-1:0]      chunks_r;
  logic [FILL_W-1:0]     fill_r;
  logic [HANDLE_W-1:0]   h_r;
  logic [STATUS_W-1:0]   status_r;
  logic [CA_W-1:0]       cnt_addr_r;
  logic [LIN_W-1:0]      lin_r;
  logic [COUNT_W-1:0]    cnt_res_r;
  logic                  out_valid_r;
  logic [HANDLE_W-1:0]   out_h_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [OFFSET_W-1:0]   out_slot_r;
  logic [COUNT_W-1:0]    out_cnt_r;

  function automatic logic [LIN_W-1:0] lin_of(input logic [HANDLE_W-1:0] h);
    logic [31:0] ch;
    logic [31:0] el;
    ch = 32'(h >> ELEM_INDEX_BITS);
    el = 32'(h & ELEM_MASK);
    return LIN_W'(ch * 32'(CHUNK_ELEMENTS) + el);
  endfunction

  // request decode
  logic [HANDLE_W-1:0] in_h;
  logic [ACTION_W-1:0] in_act;
  logic [HANDLE_W-1:0] in_chunk;
  logic [31:0]         filled;
  logic                h_valid;
  logic                accept;
  logic                do_pop;
  logic                need_new;
  logic                exhausted;
  logic [HANDLE_W-1:0] bump_h;
  logic                list_full;

  assign in_h      = in_tdata[HANDLE_W-1:0];
  assign in_act    = in_tuser;
  assign in_chunk  = in_h >> ELEM_INDEX_BITS;
  assign in_tready = (state_r == S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign do_pop    = (free_top_r != '0);
  assign need_new  = (chunks_r == '0) || (32'(fill_r) >= 32'(CHUNK_ELEMENTS));
  assign exhausted = need_new && (32'(chunks_r) >= 32'(MAX_CHUNKS));
  assign list_full = (32'(free_top_r) >= 32'(FREE_DEPTH));

  always_comb begin
    filled = (32'(in_chunk) + 32'd1 == 32'(chunks_r)) ? 32'(fill_r) : 32'(CHUNK_ELEMENTS);
    h_valid = (32'(in_chunk) < 32'(chunks_r)) && (32'(in_chunk) < 32'(MAX_CHUNKS))
              && (32'(in_h & ELEM_MASK) < filled);
    if (need_new) begin
      bump_h = HANDLE_W'(32'(chunks_r) << ELEM_INDEX_BITS);
    end else begin
      bump_h = HANDLE_W'((32'(chunks_r - CIU_W'(1)) << ELEM_INDEX_BITS) | 32'(fill_r));
    end
  end

  // free stack
  logic                stk_we;
  logic                stk_re;
  logic [HANDLE_W-1:0] stk_rdata;
  logic [HANDLE_W-1:0] stk_chunk;
  logic [FREE_TOP_W-1:0] top_dec;

  assign top_dec   = free_top_r - FREE_TOP_W'(1);
  assign stk_re    = accept && (in_act == ACT_ALLOC) && do_pop;
  assign stk_we    = accept && (in_act == ACT_FREE) && h_valid && !list_full;
  assign stk_chunk = stk_rdata >> ELEM_INDEX_BITS;

  chpa_ram #(
    .WIDTH (HANDLE_W),
    .DEPTH (FREE_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (free_top_r[FREE_AW-1:0]),
    .wdata (in_h),
    .re    (stk_re),
    .raddr (top_dec[FREE_AW-1:0]),
    .rdata (stk_rdata)
  );

  // per-chunk free counts
  logic               cnt_we;
  logic               cnt_re;
  logic [CA_W-1:0]    cnt_raddr;
  logic [COUNT_W-1:0] cnt_rdata;
  logic [COUNT_W-1:0] cnt_new;

  always_comb begin
    cnt_re    = 1'b0;
    cnt_raddr = in_chunk[CA_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (in_act == ACT_ALLOC) begin
          cnt_re    = accept && !do_pop && !need_new;
          cnt_raddr = CA_W'(chunks_r - CIU_W'(1));
        end else begin
          cnt_re = accept && h_valid && (in_act != ACT_UNUSED);
        end
      end
      S_STK: begin
        cnt_re    = (32'(stk_chunk) < 32'(MAX_CHUNKS));
        cnt_raddr = stk_chunk[CA_W-1:0];
      end
      default: begin
        cnt_re = 1'b0;
      end
    endcase
  end

  always_comb begin
    cnt_we  = (state_r == S_CNT);
    cnt_new = cnt_rdata;
    case (cmode_r)
      CM_DEC: cnt_new = (cnt_rdata != '0) ? cnt_rdata - COUNT_W'(1) : cnt_rdata;
      CM_INC: cnt_new = (cnt_rdata < COUNT_MAX) ? cnt_rdata + COUNT_W'(1) : cnt_rdata;
      CM_ZERO: cnt_new = '0;
      CM_KEEP: begin
        cnt_new = cnt_rdata;
        cnt_we  = 1'b0;
      end
      default: begin
        cnt_new = '0;
        cnt_we  = 1'b0;
      end
    endcase
  end

  chpa_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_CHUNKS)
  ) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_addr_r),
    .wdata (cnt_new),
    .re    (cnt_re),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  logic [PROD_W-1:0] prod;
  logic              out_free;

  assign prod     = PROD_W'(lin_r) * PROD_W'(esize_r);
  assign out_free = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      esize_r     <= ESIZE_RESET;
      free_top_r  <= '0;
      chunks_r    <= '0;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        esize_r <= cfg_wdata;
      end
      // S_MUL reloads the output register itself when it drains
      if (out_valid_r && out_tready && state_r != S_MUL) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            cnt_addr_r <= in_chunk[CA_W-1:0];
            h_r        <= in_h;
            status_r   <= ST_OK;
            lin_r      <= '0;
            cnt_res_r  <= '0;
            cmode_r    <= CM_NONE;
            if (in_act == ACT_ALLOC) begin
              if (do_pop) begin
                free_top_r <= top_dec;
                state_r    <= S_STK;
              end else if (exhausted) begin
                h_r      <= '0;
                status_r <= ST_EXHAUSTED;
                state_r  <= S_MUL;
              end else begin
                h_r     <= bump_h;
                state_r <= S_CNT;
                if (need_new) begin
                  cnt_addr_r <= CA_W'(chunks_r);
                  chunks_r   <= chunks_r + CIU_W'(1);
                  fill_r     <= FILL_W'(1);
                  cmode_r    <= CM_ZERO;
                end else begin
                  cnt_addr_r <= CA_W'(chunks_r - CIU_W'(1));
                  fill_r     <= fill_r + FILL_W'(1);
                  cmode_r    <= CM_KEEP;
                end
              end
            end else if (in_act == ACT_UNUSED || !h_valid) begin
              status_r <= ST_INVALID;
              state_r  <= S_MUL;
            end else begin
              state_r <= S_CNT;
              cmode_r <= CM_KEEP;
              if (in_act == ACT_FREE) begin
                if (list_full) begin
                  status_r <= ST_FULL;
                end else begin
                  free_top_r <= free_top_r + FREE_TOP_W'(1);
                  cmode_r    <= CM_INC;
                end
              end
            end
          end
        end
        S_STK: begin
          h_r        <= stk_rdata;
          cnt_addr_r <= stk_chunk[CA_W-1:0];
          cmode_r    <= (32'(stk_chunk) < 32'(MAX_CHUNKS)) ? CM_DEC : CM_NONE;
          state_r    <= S_CNT;
        end
        S_CNT: begin
          lin_r     <= lin_of(h_r);
          cnt_res_r <= cnt_new;
          state_r   <= S_MUL;
        end
        S_MUL: begin
          // hold until the output register is free
          if (out_free) begin
            out_valid_r  <= 1'b1;
            out_h_r      <= h_r;
            out_status_r <= status_r;
            out_slot_r   <= prod[OFFSET_W-1:0];
            out_cnt_r    <= cnt_res_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_cnt_r, out_slot_r, out_h_r};
  assign out_tuser  = out_status_r;

  `CHPA_ASSERT_IMPLY(a_top_bound, clk, rst_n, 1'b1, 32'(free_top_r) <= 32'(FREE_DEPTH))
  `CHPA_ASSERT_IMPLY(a_fill_bound, clk, rst_n, chunks_r != '0, 32'(fill_r) <= 32'(CHUNK_ELEMENTS))
  `CHPA_ASSERT_IMPLY(a_chunk_bound, clk, rst_n, 1'b1, 32'(chunks_r) <= 32'(MAX_CHUNKS))
  `CHPA_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, accept, !in_tready)

endmodule
